// File: rtl/svd_pkg.sv
// ----------------------------------------------------------------------------
// svd_pkg
// Shared constants and control types for the version set difference unit.
// ----------------------------------------------------------------------------
package svd_pkg;

  localparam int STORE_DEPTH = 1024;
  localparam int GROUP_BITS  = 16;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int GRP_W       = 16;
  localparam int VER_W       = 63;
  localparam int TIME_W      = 32;
  localparam int KEY_W       = GROUP_BITS + VER_W;

  localparam logic FUNC_ADD   = 1'b0;
  localparam logic FUNC_CHECK = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic accept;     // idle, input item may be taken
    logic start;      // check item taken: clear flags, pass 0
    logic next_pass;  // switch to slice-outer pass
    logic clr_i;
    logic inc_i;
    logic latch;      // capture outer key, clear j
    logic inc_j;
    logic set_flag;   // flag the outer side of this pass
    logic report;     // load result, empty stores
  } svd_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_check;
    logic ocnt_zero;
    logic icnt_zero;
    logic flag_pass;
    logic match;
    logic i_last;
    logic j_last;
    logic out_free;
  } svd_sts_t;

endpackage

// File: rtl/svd_if.sv
// ----------------------------------------------------------------------------
// svd_in_if / svd_out_if
// Valid/ready channels for record items and check results.
// ----------------------------------------------------------------------------
interface svd_in_if;
  logic                     valid;
  logic                     ready;
  logic                     func;
  logic                     side;
  logic [svd_pkg::GRP_W-1:0]  group_id;
  logic [svd_pkg::VER_W-1:0]  version;
  logic [svd_pkg::TIME_W-1:0] stamp;
  modport source (output valid, func, side, group_id, version, stamp, input ready);
  modport sink   (input valid, func, side, group_id, version, stamp, output ready);
endinterface

interface svd_out_if;
  logic valid;
  logic ready;
  logic replica_dirty;
  logic slice_dirty;
  logic overflow;
  modport source (output valid, replica_dirty, slice_dirty, overflow, input ready);
  modport sink   (input valid, replica_dirty, slice_dirty, overflow, output ready);
endinterface

// File: rtl/svd_ram.sv
// ----------------------------------------------------------------------------
// svd_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module svd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/svd_ctrl.sv
// ----------------------------------------------------------------------------
// svd_ctrl
// Sequencer for the check: two nested-scan passes, then report.
// ----------------------------------------------------------------------------
module svd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  svd_pkg::svd_sts_t sts,
  output svd_pkg::svd_cmd_t cmd
);
  import svd_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PSTART = 3'd1;
  localparam logic [2:0] ST_OREAD  = 3'd2;
  localparam logic [2:0] ST_OLATCH = 3'd3;
  localparam logic [2:0] ST_IREAD  = 3'd4;
  localparam logic [2:0] ST_ICMP   = 3'd5;
  localparam logic [2:0] ST_REPORT = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       pass_r, pass_nxt;
  logic       end_pass;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    pass_nxt  = pass_r;
    end_pass  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.accept = 1'b1;
        if (sts.in_check) begin
          cmd.start = 1'b1;
          pass_nxt  = 1'b0;
          state_nxt = ST_PSTART;
        end
      end
      ST_PSTART: begin
        if (sts.ocnt_zero || sts.flag_pass) begin
          end_pass = 1'b1;
        end else begin
          cmd.clr_i = 1'b1;
          state_nxt = ST_OREAD;
        end
      end
      ST_OREAD: state_nxt = ST_OLATCH;
      ST_OLATCH: begin
        cmd.latch = 1'b1;
        if (sts.icnt_zero) begin
          cmd.set_flag = 1'b1;
          end_pass     = 1'b1;
        end else begin
          state_nxt = ST_IREAD;
        end
      end
      ST_IREAD: state_nxt = ST_ICMP;
      ST_ICMP: begin
        if (sts.match) begin
          if (sts.i_last) begin
            end_pass = 1'b1;
          end else begin
            cmd.inc_i = 1'b1;
            state_nxt = ST_OREAD;
          end
        end else if (sts.j_last) begin
          cmd.set_flag = 1'b1;
          end_pass     = 1'b1;
        end else begin
          cmd.inc_j = 1'b1;
          state_nxt = ST_IREAD;
        end
      end
      ST_REPORT: begin
        if (sts.out_free) begin
          cmd.report = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (end_pass) begin
      if (!pass_r) begin
        cmd.next_pass = 1'b1;
        pass_nxt      = 1'b1;
        state_nxt     = ST_PSTART;
      end else begin
        state_nxt = ST_REPORT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pass_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pass_r  <= pass_nxt;
    end
  end

endmodule

// File: rtl/svd_dp.sv
// ----------------------------------------------------------------------------
// svd_dp
// Record stores, scan indexes, dirty/overflow flags and result register.
// ----------------------------------------------------------------------------
module svd_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [svd_pkg::TIME_W-1:0] cfg_wdata,
  svd_in_if.sink            in_item,
  svd_out_if.source         out_item,
  input  svd_pkg::svd_cmd_t cmd,
  output svd_pkg::svd_sts_t sts
);
  import svd_pkg::*;

  logic [TIME_W-1:0] from_time_r;
  logic [CNT_W-1:0]  rcnt_r, scnt_r;
  logic              drop_r;
  logic              pass_r;
  logic              rflag_r, sflag_r;
  logic [ADDR_W-1:0] i_r, j_r;
  logic [KEY_W-1:0]  key_r;
  logic              out_valid_r, out_rd_r, out_sd_r, out_ov_r;

  logic [KEY_W-1:0]  wkey, r_rdata, s_rdata, o_rdata, i_rdata;
  logic              add_go, r_full, s_full, r_we, s_we;
  logic [CNT_W-1:0]  ocnt, icnt;

  assign wkey   = {in_item.group_id[GROUP_BITS-1:0], in_item.version};
  assign add_go = cmd.accept && in_item.valid && (in_item.func == FUNC_ADD)
                  && (in_item.stamp >= from_time_r);
  assign r_full = (rcnt_r == CNT_W'(STORE_DEPTH));
  assign s_full = (scnt_r == CNT_W'(STORE_DEPTH));
  assign r_we   = add_go && !in_item.side && !r_full;
  assign s_we   = add_go &&  in_item.side && !s_full;

  svd_ram #(.WIDTH(KEY_W), .DEPTH(STORE_DEPTH)) u_rep_ram (
    .clk(clk), .we(r_we), .waddr(rcnt_r[ADDR_W-1:0]), .wdata(wkey),
    .raddr(pass_r ? j_r : i_r), .rdata(r_rdata)
  );

  svd_ram #(.WIDTH(KEY_W), .DEPTH(STORE_DEPTH)) u_slc_ram (
    .clk(clk), .we(s_we), .waddr(scnt_r[ADDR_W-1:0]), .wdata(wkey),
    .raddr(pass_r ? i_r : j_r), .rdata(s_rdata)
  );

  assign o_rdata = pass_r ? s_rdata : r_rdata;
  assign i_rdata = pass_r ? r_rdata : s_rdata;
  assign ocnt    = pass_r ? scnt_r : rcnt_r;
  assign icnt    = pass_r ? rcnt_r : scnt_r;

  assign in_item.ready      = cmd.accept;
  assign sts.in_check       = in_item.valid && (in_item.func == FUNC_CHECK);
  assign sts.ocnt_zero      = (ocnt == '0);
  assign sts.icnt_zero      = (icnt == '0);
  assign sts.flag_pass      = pass_r ? sflag_r : rflag_r;
  assign sts.match          = (i_rdata == key_r);
  assign sts.i_last         = ((CNT_W'(i_r) + CNT_W'(1)) == ocnt);
  assign sts.j_last         = ((CNT_W'(j_r) + CNT_W'(1)) == icnt);
  assign sts.out_free       = !out_valid_r || out_item.ready;

  assign out_item.valid         = out_valid_r;
  assign out_item.replica_dirty = out_rd_r;
  assign out_item.slice_dirty   = out_sd_r;
  assign out_item.overflow      = out_ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      from_time_r <= '0;
      rcnt_r      <= '0;
      scnt_r      <= '0;
      drop_r      <= 1'b0;
      pass_r      <= 1'b0;
      rflag_r     <= 1'b0;
      sflag_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        from_time_r <= cfg_wdata;
      end
      if (r_we) begin
        rcnt_r <= rcnt_r + CNT_W'(1);
      end
      if (s_we) begin
        scnt_r <= scnt_r + CNT_W'(1);
      end
      if (add_go && (in_item.side ? s_full : r_full)) begin
        drop_r <= 1'b1;
      end
      if (cmd.start) begin
        pass_r  <= 1'b0;
        rflag_r <= 1'b0;
        sflag_r <= 1'b0;
      end
      if (cmd.next_pass) begin
        pass_r <= 1'b1;
      end
      if (cmd.set_flag) begin
        if (pass_r) begin
          sflag_r <= 1'b1;
        end else begin
          rflag_r <= 1'b1;
        end
      end
      if (out_valid_r && out_item.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.report) begin
        out_valid_r <= 1'b1;
        rcnt_r      <= '0;
        scnt_r      <= '0;
        drop_r      <= 1'b0;
      end
    end
  end

  // scan indexes and payload
  always_ff @(posedge clk) begin
    if (cmd.clr_i) begin
      i_r <= '0;
    end else if (cmd.inc_i) begin
      i_r <= i_r + ADDR_W'(1);
    end
    if (cmd.latch) begin
      key_r <= o_rdata;
      j_r   <= '0;
    end else if (cmd.inc_j) begin
      j_r <= j_r + ADDR_W'(1);
    end
    if (cmd.report) begin
      out_rd_r <= rflag_r;
      out_sd_r <= sflag_r;
      out_ov_r <= drop_r;
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rcnt_r <= CNT_W'(STORE_DEPTH) && scnt_r <= CNT_W'(STORE_DEPTH))
    else $error("store count past depth");
  a_report_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.report |=> rcnt_r == '0 && scnt_r == '0 && !drop_r && out_valid_r)
    else $error("report did not empty stores");
  a_flag_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.set_flag |-> !cmd.accept)
    else $error("flag set while idle");
  a_report_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.report |-> (!out_valid_r || out_item.ready))
    else $error("result overwritten");
`endif

endmodule

// File: rtl/sorted_version_set_diff_unit.sv
// ----------------------------------------------------------------------------
// sorted_version_set_diff_unit
// Set difference of replica and slice record stores, keyed by group/version.
// ----------------------------------------------------------------------------
// An add item (func 0) writes its group id and version into the replica or
// slice store, one item per cycle while no check is running, unless its
// stamp is before from_time. A store holds STORE_DEPTH records; further adds
// are dropped and raise the overflow flag. A check item (func 1) compares the
// stores as sets of keys and returns one result: replica_dirty if the replica
// holds a key the slice lacks, slice_dirty for the reverse, plus overflow;
// then both stores are emptied. The check scans every key of one store
// against the other over the single read port of each store RAM, for both
// directions, reading each inner key (IREAD) and then comparing it (ICMP),
// and ends a direction early once it is known dirty. No input item is taken
// during a check. A result may wait at the output while adds proceed.
module sorted_version_set_diff_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [svd_pkg::TIME_W-1:0] cfg_wdata,
  svd_in_if.sink                     in_item,
  svd_out_if.source                  out_item
);
  import svd_pkg::*;

  svd_cmd_t cmd;
  svd_sts_t sts;

  // sequencer: idle, per-pass scan, report
  svd_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .sts(sts), .cmd(cmd)
  );

  // stores, indexes, flags, result register
  svd_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_item(in_item), .out_item(out_item), .cmd(cmd), .sts(sts)
  );

endmodule
